FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/saob_pkg.sv
// ----------------------------------------------------------------------------
// Sorted ask book package
// Beat types, command and status codes, cell control for the order row.
// ----------------------------------------------------------------------------
package saob_pkg;

	localparam int PRICE_W = 24;
	localparam int QTY_W   = 32;
	localparam int POS_W   = 10;
	localparam int COST_W  = 63;
	localparam int PROD_W  = PRICE_W + QTY_W;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_BUY    = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;
	localparam logic [1:0] STAT_PARTIAL = 2'd3;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef struct packed {
		logic [1:0]         cmd;
		logic [PRICE_W-1:0] order_price;
		logic [QTY_W-1:0]   quantity;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic [COST_W-1:0] total_cost;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ADD,
		CELL_DEL,
		CELL_HEAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   shares;
		logic [POS_W-1:0]   pos;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUY,
		ST_FIN
	} state_t;

endpackage

FILE: src/sorted_ask_book_engine_top.sv
// ----------------------------------------------------------------------------
// Sorted ask book engine
// Ask side of an order book kept in a shifting row of rank cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req with start high; the beat is taken at the edge
//   where start is high and busy is low.
//   Result channel: done pulses for one cycle with rsp; it cannot be stalled.
//   Add and remove: the row shifts in the accept cycle, the result shows the
//   next cycle and busy stays low, so one command per cycle is taken.
//   Buy: one order taken from the head per step (each step drops or trims
//   the head rank), plus one closing step that adds the last product to the
//   cost and one step that latches the result; busy stays high through these
//   steps and drops as the result shows. The head multiply is registered and
//   summed into the running cost in the cycle after.
//   Full book add answers status 1, remove past the last rank status 2, a
//   buy the book cannot fill in full status 3. Cost saturates at 2^63-1.
//   Reset clears the order count, so the book is empty; cell contents are
//   not cleared and only ranks below the count are ever used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_ask_book_engine_top #(
	parameter int BOOK_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  saob_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output saob_pkg::rsp_t  rsp
);

	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

	saob_pkg::state_t    state_q, state_d;
	saob_pkg::cell_ctl_t ctl;

	logic [CNT_W-1:0]              count_q;
	logic [saob_pkg::QTY_W-1:0]    want_q;
	logic [saob_pkg::COST_W-1:0]   cost_q;
	logic [saob_pkg::PROD_W-1:0]   prod_s1;
	logic                          prod_v_s1;
	logic                          done_q;
	saob_pkg::rsp_t                rsp_q;

	logic [saob_pkg::PRICE_W-1:0] price_w  [BOOK_DEPTH];
	logic [saob_pkg::QTY_W-1:0]   shares_w [BOOK_DEPTH];
	logic                         stay_w   [BOOK_DEPTH];

	logic                          accept;
	logic                          book_full;
	logic                          pos_ok;
	logic                          buy_step;
	logic                          buy_empty;
	logic                          head_drop;
	logic [saob_pkg::QTY_W-1:0]    fill;
	logic [saob_pkg::PROD_W-1:0]   prod_d;
	logic [saob_pkg::COST_W:0]     cost_sum;
	logic [saob_pkg::COST_W-1:0]   cost_next;

	genvar gi;
	generate
		for (gi = 0; gi < BOOK_DEPTH; gi++) begin : g_cell
			logic [saob_pkg::PRICE_W-1:0] lp, rp;
			logic [saob_pkg::QTY_W-1:0]   ls, rs;
			logic                         lst;
			if (gi == 0) begin : g_first
				assign lp  = price_w[gi];
				assign ls  = shares_w[gi];
				assign lst = 1'b1;
			end else begin : g_mid
				assign lp  = price_w[gi-1];
				assign ls  = shares_w[gi-1];
				assign lst = stay_w[gi-1];
			end
			if (gi == BOOK_DEPTH - 1) begin : g_last
				assign rp = price_w[gi];
				assign rs = shares_w[gi];
			end else begin : g_inner
				assign rp = price_w[gi+1];
				assign rs = shares_w[gi+1];
			end
			saob_cell #(
				.BOOK_DEPTH (BOOK_DEPTH),
				.IDX        (gi)
			) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.count        (count_q),
				.left_price   (lp),
				.left_shares  (ls),
				.left_stay    (lst),
				.right_price  (rp),
				.right_shares (rs),
				.price        (price_w[gi]),
				.shares       (shares_w[gi]),
				.stay         (stay_w[gi])
			);
		end
	endgenerate

	assign accept    = start && !busy;
	assign book_full = count_q == CNT_W'(BOOK_DEPTH);
	assign pos_ok    = 32'(req.position) < 32'(count_q);
	assign buy_step  = (state_q == saob_pkg::ST_BUY) && (want_q != '0) && (count_q != '0);
	assign buy_empty = (state_q == saob_pkg::ST_BUY) && (count_q == '0);
	assign fill      = (shares_w[0] < want_q) ? shares_w[0] : want_q;
	assign head_drop = shares_w[0] == fill;
	assign prod_d    = {{saob_pkg::PRICE_W{1'b0}}, fill}
	                 * {{saob_pkg::QTY_W{1'b0}}, price_w[0]};
	assign cost_sum  = {1'b0, cost_q} + (saob_pkg::COST_W + 1)'(prod_s1);
	assign cost_next = cost_sum[saob_pkg::COST_W] ? saob_pkg::COST_MAX
	                 : cost_sum[saob_pkg::COST_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			saob_pkg::ST_IDLE: begin
				if (accept && req.cmd == saob_pkg::CMD_BUY) begin
					state_d = saob_pkg::ST_BUY;
				end
			end
			saob_pkg::ST_BUY: begin
				if (!buy_step) begin
					state_d = saob_pkg::ST_FIN;
				end
			end
			saob_pkg::ST_FIN: state_d = saob_pkg::ST_IDLE;
			default:          state_d = saob_pkg::ST_IDLE;
		endcase
	end

	// outputs and row control
	always_comb begin
		busy       = state_q != saob_pkg::ST_IDLE;
		ctl.op     = saob_pkg::CELL_HOLD;
		ctl.price  = req.order_price;
		ctl.shares = req.quantity;
		ctl.pos    = req.position;
		case (state_q)
			saob_pkg::ST_IDLE: begin
				if (accept && req.cmd == saob_pkg::CMD_ADD && !book_full) begin
					ctl.op = saob_pkg::CELL_ADD;
				end else if (accept && req.cmd == saob_pkg::CMD_REMOVE && pos_ok) begin
					ctl.op = saob_pkg::CELL_DEL;
				end
			end
			saob_pkg::ST_BUY: begin
				ctl.pos    = '0;
				ctl.shares = shares_w[0] - fill;
				if (buy_step) begin
					ctl.op = head_drop ? saob_pkg::CELL_DEL : saob_pkg::CELL_HEAD;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= saob_pkg::ST_IDLE;
			count_q   <= '0;
			prod_v_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			prod_v_s1 <= buy_step;
			done_q    <= (state_q == saob_pkg::ST_FIN)
			          || (accept && req.cmd != saob_pkg::CMD_BUY);
			case (ctl.op)
				saob_pkg::CELL_ADD: count_q <= count_q + 1'b1;
				saob_pkg::CELL_DEL: count_q <= count_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		if (accept) begin
			want_q <= req.quantity;
			cost_q <= '0;
		end else begin
			if (buy_step) begin
				want_q <= want_q - fill;
			end
			if (prod_v_s1) begin
				cost_q <= cost_next;
			end
		end
		if (state_q == saob_pkg::ST_FIN) begin
			rsp_q.total_cost <= cost_q;
			rsp_q.status     <= (want_q != '0) ? saob_pkg::STAT_PARTIAL : saob_pkg::STAT_OK;
		end else if (accept) begin
			rsp_q.total_cost <= '0;
			if (req.cmd == saob_pkg::CMD_ADD && book_full) begin
				rsp_q.status <= saob_pkg::STAT_FULL;
			end else if (req.cmd == saob_pkg::CMD_REMOVE && !pos_ok) begin
				rsp_q.status <= saob_pkg::STAT_RANGE;
			end else begin
				rsp_q.status <= saob_pkg::STAT_OK;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_IMPL(a_done_idle, done, !busy, "result beat while a buy is still running")
	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(BOOK_DEPTH), "order count beyond book depth")
	`ASSERT_NEXT(a_accept_moves, accept, done || busy, "accepted beat neither answered nor running")
	`ASSERT_NEXT(a_empty_ends_buy, buy_empty, state_q == saob_pkg::ST_FIN, "buy open on empty book")

endmodule

FILE: src/saob_cell.sv
// ----------------------------------------------------------------------------
// Order row cell
// Holds one rank of the book; inserts, shifts in from a neighbor or updates
// the head shares as the broadcast control asks.
// ----------------------------------------------------------------------------
module saob_cell #(
	parameter int BOOK_DEPTH = 64,
	parameter int IDX        = 0
) (
	input  logic                              clk,
	input  saob_pkg::cell_ctl_t               ctl,
	input  logic [$clog2(BOOK_DEPTH+1)-1:0]   count,
	input  logic [saob_pkg::PRICE_W-1:0]      left_price,
	input  logic [saob_pkg::QTY_W-1:0]        left_shares,
	input  logic                              left_stay,
	input  logic [saob_pkg::PRICE_W-1:0]      right_price,
	input  logic [saob_pkg::QTY_W-1:0]        right_shares,
	output logic [saob_pkg::PRICE_W-1:0]      price,
	output logic [saob_pkg::QTY_W-1:0]        shares,
	output logic                              stay
);

	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

	logic [saob_pkg::PRICE_W-1:0] price_q;
	logic [saob_pkg::QTY_W-1:0]   shares_q;
	logic                         live;
	logic                         at_or_after;

	assign live        = CNT_W'(IDX) < count;
	assign stay        = live && (price_q <= ctl.price);
	assign at_or_after = saob_pkg::POS_W'(IDX) >= ctl.pos;
	assign price       = price_q;
	assign shares      = shares_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			saob_pkg::CELL_ADD: begin
				if (!stay) begin
					if (left_stay) begin
						price_q  <= ctl.price;
						shares_q <= ctl.shares;
					end else begin
						price_q  <= left_price;
						shares_q <= left_shares;
					end
				end
			end
			saob_pkg::CELL_DEL: begin
				if (at_or_after) begin
					price_q  <= right_price;
					shares_q <= right_shares;
				end
			end
			saob_pkg::CELL_HEAD: begin
				if (IDX == 0) begin
					shares_q <= ctl.shares;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: dv/sorted_ask_book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ask book checker
// Watches the command and result channels of the ask book engine. It keeps its
// own sorted copy of the resting orders and works out the answer to every
// accepted command. Each result is compared field by field with the oldest
// outstanding answer. It reports the mismatch count, the number of answers
// still outstanding and the number of resting orders.
// ----------------------------------------------------------------------------
module sorted_ask_book_checker #(
	parameter int BOOK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  saob_pkg::req_t   req,
	input  logic             busy,
	input  logic             done,
	input  saob_pkg::rsp_t   rsp,
	output int               fail_count,
	output int               pending,
	output int               resting
);
	import saob_pkg::*;

	logic [PRICE_W-1:0] ask_price  [BOOK_DEPTH];
	logic [QTY_W-1:0]   ask_shares [BOOK_DEPTH];
	int                 ask_count;
	rsp_t               owed_answers[$];
	int                 mismatches;

	assign fail_count = mismatches;

	initial begin
		mismatches = 0;
		ask_count  = 0;
		pending    = 0;
		resting    = 0;
	end

	function automatic void drop_rank(int r);
		for (int i = r; i + 1 < ask_count; i++) begin
			ask_price[i]  = ask_price[i + 1];
			ask_shares[i] = ask_shares[i + 1];
		end
		ask_count--;
	endfunction

	function automatic rsp_t book_answer(req_t r);
		rsp_t             ans;
		int               slot;
		logic [QTY_W-1:0] want;
		logic [QTY_W-1:0] fill;
		logic [63:0]      cost;
		logic [63:0]      part;
		ans.total_cost = '0;
		ans.status     = STAT_OK;
		case (r.cmd)
			CMD_ADD: begin
				if (ask_count >= BOOK_DEPTH) begin
					ans.status = STAT_FULL;
				end else begin
					slot = 0;
					while (slot < ask_count && ask_price[slot] <= r.order_price)
						slot++;
					for (int i = ask_count; i > slot; i--) begin
						ask_price[i]  = ask_price[i - 1];
						ask_shares[i] = ask_shares[i - 1];
					end
					ask_price[slot]  = r.order_price;
					ask_shares[slot] = r.quantity;
					ask_count++;
				end
			end
			CMD_REMOVE: begin
				if (int'(r.position) < ask_count)
					drop_rank(int'(r.position));
				else
					ans.status = STAT_RANGE;
			end
			CMD_BUY: begin
				want = r.quantity;
				cost = '0;
				while (want != 0 && ask_count > 0) begin
					fill = (ask_shares[0] < want) ? ask_shares[0] : want;
					part = 64'(fill) * 64'(ask_price[0]);
					if (part > {1'b0, COST_MAX} - cost)
						cost = {1'b0, COST_MAX};
					else
						cost = cost + part;
					ask_shares[0] = ask_shares[0] - fill;
					want = want - fill;
					if (ask_shares[0] == 0)
						drop_rank(0);
				end
				ans.total_cost = cost[COST_W-1:0];
				ans.status     = (want != 0) ? STAT_PARTIAL : STAT_OK;
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			ask_count = 0;
			owed_answers.delete();
			pending <= 0;
			resting <= 0;
		end else begin
			if (done) begin
				if (owed_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: cost %0d status %0d",
							rsp.total_cost, rsp.status);
				end else begin
					exp_rsp = owed_answers.pop_front();
					if (rsp.total_cost !== exp_rsp.total_cost ||
						rsp.status !== exp_rsp.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: cost exp %0d got %0d, status exp %0d got %0d",
								exp_rsp.total_cost, rsp.total_cost,
								exp_rsp.status, rsp.status);
					end
				end
			end
			if (start && !busy)
				owed_answers.push_back(book_answer(req));
			pending <= owed_answers.size();
			resting <= ask_count;
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ask book engine testbench
// Drives add, remove, buy and unused command codes into the engine: a directed opening on
// the corner cases, then shaped random traffic that fills the book, mixes and
// drains it, with phases of sender idling. The checker beside the engine
// predicts and compares every result beat; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import saob_pkg::*;

	localparam int DEPTH     = 64;
	localparam int RAND_BEATS = 550;

	typedef enum int {
		MIX_FILL,
		MIX_BLEND,
		MIX_DRAIN
	} traffic_mix_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   resting;
	int   idle_pct;

	sorted_ask_book_engine_top #(
		.BOOK_DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	sorted_ask_book_checker #(
		.BOOK_DEPTH(DEPTH)
	) book_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending),
		.resting   (resting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic req_t mk_req(logic [1:0] cmd, logic [PRICE_W-1:0] price,
		logic [QTY_W-1:0] qty, logic [POS_W-1:0] pos);
		req_t r;
		r.cmd         = cmd;
		r.order_price = price;
		r.quantity    = qty;
		r.position    = pos;
		return r;
	endfunction

	function automatic req_t any_req();
		return mk_req(2'($urandom_range(0, 3)), 24'($urandom), $urandom, 10'($urandom));
	endfunction

	function automatic logic [PRICE_W-1:0] pick_price();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 24'(1000 + $urandom_range(0, 15));
		else if (sel < 8)
			return 24'($urandom);
		else if (sel == 8)
			return '0;
		else
			return '1;
	endfunction

	function automatic logic [QTY_W-1:0] pick_add_qty();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic logic [QTY_W-1:0] pick_buy_qty();
		case ($urandom_range(0, 9))
			6: return '0;
			7: return $urandom;
			8: return '1;
			9: return $urandom_range(1, 2000);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	function automatic req_t shaped_req(traffic_mix_t mix, int count);
		req_t r;
		int   pick;
		int   add_cut;
		int   rem_cut;
		int   buy_cut;
		r    = any_req();
		pick = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin add_cut = 85; rem_cut = 93; buy_cut = 100; end
			MIX_BLEND: begin add_cut = 45; rem_cut = 65; buy_cut = 95; end
			default:   begin add_cut = 20; rem_cut = 50; buy_cut = 100; end
		endcase
		if (pick < add_cut) begin
			r.cmd         = CMD_ADD;
			r.order_price = pick_price();
			r.quantity    = pick_add_qty();
		end else if (pick < rem_cut) begin
			r.cmd = CMD_REMOVE;
			if ($urandom_range(0, 4) != 0)
				r.position = 10'($urandom_range(0, count));
		end else if (pick < buy_cut) begin
			r.cmd      = CMD_BUY;
			r.quantity = pick_buy_qty();
		end
		return r;
	endfunction

	// one command beat, after a random number of idle cycles
	task automatic issue(req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			req   <= any_req();
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic top_up_book();
		while (resting < DEPTH)
			issue(mk_req(CMD_ADD, pick_price(), pick_add_qty(), 10'($urandom)));
		issue(mk_req(CMD_ADD, pick_price(), pick_add_qty(), 10'($urandom)));
		issue(mk_req(CMD_REMOVE, 24'($urandom), $urandom, 10'(DEPTH)));
		issue(mk_req(CMD_ADD, '1, '1, '1));
	endtask

	initial begin
		traffic_mix_t mix;
		int           slot;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty book corners
		issue(mk_req(CMD_BUY, '0, 32'd5, '0));
		issue(mk_req(CMD_BUY, '1, '0, '1));
		issue(mk_req(CMD_REMOVE, '0, '0, '0));
		issue(mk_req(2'd3, '1, '1, '1));
		// zero-share order at the head, equal prices, extremes
		issue(mk_req(CMD_ADD, '0, '0, '0));
		issue(mk_req(CMD_ADD, '1, '1, '1));
		issue(mk_req(CMD_ADD, 24'd100, 32'd10, '0));
		issue(mk_req(CMD_ADD, 24'd100, 32'd20, '0));
		issue(mk_req(CMD_ADD, 24'd50, 32'd5, '0));
		issue(mk_req(CMD_ADD, 24'd100, 32'd0, '0));
		issue(mk_req(CMD_REMOVE, '0, '0, '1));
		issue(mk_req(CMD_REMOVE, '0, '0, 10'd6));
		issue(mk_req(CMD_REMOVE, '0, '0, 10'd5));
		issue(mk_req(CMD_BUY, '0, '0, '0));
		issue(mk_req(CMD_BUY, '0, 32'd3, '0));
		issue(mk_req(CMD_BUY, '0, 32'd12, '0));
		issue(mk_req(CMD_REMOVE, '0, '0, '0));
		issue(mk_req(CMD_ADD, '1, '1, '0));
		issue(mk_req(CMD_ADD, '1, 32'd1, '0));
		issue(mk_req(CMD_BUY, '0, '1, '0));
		issue(mk_req(CMD_ADD, 24'h800000, 32'h80000000, 10'h200));
		issue(mk_req(CMD_REMOVE, '0, '0, '0));
		issue(mk_req(2'd3, '0, '0, '0));

		for (int i = 0; i < RAND_BEATS; i++) begin
			slot = i % 200;
			if (slot < 50)
				idle_pct = 0;
			else if (slot < 100)
				idle_pct = 78;
			else if (slot < 150)
				idle_pct = 23;
			else
				idle_pct = 0;
			if (i == 120 || i == 330 || i == 480)
				top_up_book();
			mix = traffic_mix_t'((i / 40) % 3);
			issue(shaped_req(mix, resting));
		end
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/saob_pkg.sv
src/saob_cell.sv
src/sorted_ask_book_engine_top.sv
dv/sorted_ask_book_checker.sv
dv/tb.sv
